// File: rtl/pupda_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pupda_pkg: shared constants and helpers for the 2x upscaler
// Register indexes, default size limits, pixel layout and channel averaging.
// ----------------------------------------------------------------------------
package pupda_pkg;

    localparam int CFG_W       = 12;   // configuration data width
    localparam int COORD_W     = 12;   // target coordinate width
    localparam int CHAN_W      = 8;
    localparam int PIX_W       = 4 * CHAN_W;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;

    // register indexes
    localparam logic CFG_SRC_WIDTH  = 1'b0;
    localparam logic CFG_SRC_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] t_pix;   // blue in the low byte

    // per-channel (a+b)/2, truncated
    function automatic t_pix pix_avg2(input t_pix a, input t_pix b);
        t_pix        res;
        logic [8:0]  s;
        res = '0;
        for (int k = 0; k < 4; k++) begin
            s = {1'b0, a[k*CHAN_W +: CHAN_W]} + {1'b0, b[k*CHAN_W +: CHAN_W]};
            res[k*CHAN_W +: CHAN_W] = s[8:1];
        end
        return res;
    endfunction

    // per-channel (a+b+c+d)/4, truncated
    function automatic t_pix pix_avg4(input t_pix a, input t_pix b,
                                      input t_pix c, input t_pix d);
        t_pix        res;
        logic [9:0]  s;
        res = '0;
        for (int k = 0; k < 4; k++) begin
            s = {2'b00, a[k*CHAN_W +: CHAN_W]} + {2'b00, b[k*CHAN_W +: CHAN_W]}
              + {2'b00, c[k*CHAN_W +: CHAN_W]} + {2'b00, d[k*CHAN_W +: CHAN_W]};
            res[k*CHAN_W +: CHAN_W] = s[9:2];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// File: rtl/pixel_upscale_double_averaging_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_upscale_double_averaging_unit: streaming 2x upscaler with averaging
//
// Source pixels enter in raster order on the input channel (i_in_valid /
// o_in_ready). Each source pixel s0 becomes a 2x2 target block: s0, the
// average with its right neighbour, with the pixel below, and of all four.
// A block leaves once its right and lower neighbours have arrived, so one
// source item releases zero to four blocks (0..16 result items) on the
// output channel (o_out_valid / i_out_ready), each tagged with its target
// column and row. o_out_last marks the final result of an item and
// o_frame_done the final result of the frame.
// The previous source row lives in a line RAM (one entry per column); it is
// read and written in the cycle an item is accepted.
// An accepted item passes the staging register and the emitter; its results
// leave from the output register. The output drains one result per cycle
// while i_out_ready is held, so an item releasing k blocks yields 4k results,
// four per item over a whole frame. Items releasing nothing skip the emitter.
// The block keeps accepting while results wait: one staged item and one
// emitting item are held, so a stall on the output back-pressures the input
// only once both are occupied. Reset (synchronous, active low) restarts the
// frame at column and row zero with a 1x1 size; a register write also
// restarts the frame. The line RAM needs no clearing pass.
// ----------------------------------------------------------------------------
module pixel_upscale_double_averaging_unit #(
    parameter int MAX_WIDTH  = pupda_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = pupda_pkg::MAX_HEIGHT_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // configuration
    input  wire                               i_cfg_we,
    input  wire                               i_cfg_idx,
    input  wire  [pupda_pkg::CFG_W-1:0]       i_cfg_data,
    // source pixels
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire  [pupda_pkg::CHAN_W-1:0]      i_in_blue,
    input  wire  [pupda_pkg::CHAN_W-1:0]      i_in_green,
    input  wire  [pupda_pkg::CHAN_W-1:0]      i_in_red,
    input  wire  [pupda_pkg::CHAN_W-1:0]      i_in_alpha,
    // target pixels
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output logic [pupda_pkg::COORD_W-1:0]     o_out_x,
    output logic [pupda_pkg::COORD_W-1:0]     o_out_y,
    output logic [pupda_pkg::CHAN_W-1:0]      o_out_blue,
    output logic [pupda_pkg::CHAN_W-1:0]      o_out_green,
    output logic [pupda_pkg::CHAN_W-1:0]      o_out_red,
    output logic [pupda_pkg::CHAN_W-1:0]      o_out_alpha,
    output logic                              o_out_last,
    output logic                              o_frame_done
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    // block codes, in emission order
    localparam logic [1:0] BLK_UP_LEFT = 2'd0;  // (c-1, r-1)
    localparam logic [1:0] BLK_UP      = 2'd1;  // (c,   r-1), right edge
    localparam logic [1:0] BLK_LEFT    = 2'd2;  // (c-1, r),   bottom row
    localparam logic [1:0] BLK_CORNER  = 2'd3;  // (c,   r),   frame end

    localparam logic [1:0] PIX_LAST = 2'd3;

    // ---------------- configuration and position ----------------
    logic [CW-1:0] r_w_last, n_w_last;   // clamped width - 1
    logic [RW-1:0] r_h_last, n_h_last;   // clamped height - 1
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;

    always_comb begin
        if (i_cfg_data == '0) begin
            n_w_last = '0;
        end else if (32'(i_cfg_data) > 32'(MAX_WIDTH)) begin
            n_w_last = CW'(MAX_WIDTH - 1);
        end else begin
            n_w_last = CW'(i_cfg_data - 12'd1);
        end
        if (i_cfg_data == '0) begin
            n_h_last = '0;
        end else if (32'(i_cfg_data) > 32'(MAX_HEIGHT)) begin
            n_h_last = RW'(MAX_HEIGHT - 1);
        end else begin
            n_h_last = RW'(i_cfg_data - 12'd1);
        end
    end

    logic in_acc;
    assign in_acc = i_in_valid && o_in_ready;

    pupda_pkg::t_pix in_pix;
    assign in_pix = {i_in_alpha, i_in_red, i_in_green, i_in_blue};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last <= '0;
            r_h_last <= '0;
            r_col    <= '0;
            r_row    <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == pupda_pkg::CFG_SRC_WIDTH) begin
                r_w_last <= n_w_last;
            end else begin
                r_h_last <= n_h_last;
            end
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            if (r_col == r_w_last) begin
                r_col <= '0;
                r_row <= (r_row == r_h_last) ? '0 : r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // ---------------- line RAM ----------------
    // read-first: the old entry (row above) comes back while the new pixel
    // is written, so no forwarding is needed even for single-column images
    pupda_pkg::t_pix above_pix;

    pupda_ram #(
        .WIDTH (pupda_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_col),
        .i_wdata (in_pix),
        .i_re    (in_acc),
        .i_raddr (r_col),
        .o_rdata (above_pix)
    );

    // ---------------- staging register (RAM read in flight) ----------------
    logic            r_a_valid;
    logic [CW-1:0]   r_a_col;
    logic [RW-1:0]   r_a_row;
    pupda_pkg::t_pix r_a_cur;
    logic [3:0]      a_mask;
    logic [1:0]      a_first;

    // which blocks this item completes
    always_comb begin
        a_mask[BLK_UP_LEFT] = (r_a_row != '0) && (r_a_col != '0);
        a_mask[BLK_UP]      = (r_a_row != '0) && (r_a_col == r_w_last);
        a_mask[BLK_LEFT]    = (r_a_row == r_h_last) && (r_a_col != '0);
        a_mask[BLK_CORNER]  = (r_a_row == r_h_last) && (r_a_col == r_w_last);
        a_first = BLK_UP_LEFT;
        for (int i = 3; i >= 0; i--) begin
            if (a_mask[i]) begin
                a_first = 2'(i);
            end
        end
    end

    // ---------------- emitter ----------------
    logic            r_e_valid;
    logic [3:0]      r_e_mask;
    logic [1:0]      r_e_blk;
    logic [1:0]      r_e_pix;
    logic [CW-1:0]   r_e_col;
    logic [RW-1:0]   r_e_row;
    pupda_pkg::t_pix r_e_cur, r_e_above, r_e_lcur, r_e_labove;
    pupda_pkg::t_pix r_left_cur, r_left_above;

    logic        emit, e_done, xfer, nxt_found;
    logic [1:0]  nxt_blk;

    always_comb begin
        nxt_found = 1'b0;
        nxt_blk   = r_e_blk;
        for (int i = 3; i >= 0; i--) begin
            if ((i > int'(r_e_blk)) && r_e_mask[i]) begin
                nxt_found = 1'b1;
                nxt_blk   = 2'(i);
            end
        end
    end

    assign emit       = r_e_valid && (!o_out_valid || i_out_ready);
    assign e_done     = emit && (r_e_pix == PIX_LAST) && !nxt_found;
    assign xfer       = r_a_valid && (!r_e_valid || e_done);
    assign o_in_ready = !r_a_valid || xfer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_acc) begin
            r_a_valid <= 1'b1;
        end else if (xfer) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_col <= r_col;
            r_a_row <= r_row;
            r_a_cur <= in_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid    <= 1'b0;
            r_left_cur   <= '0;
            r_left_above <= '0;
        end else if (xfer) begin
            // items that complete no block only update the left neighbours
            r_e_valid    <= (a_mask != '0);
            r_left_cur   <= r_a_cur;
            r_left_above <= above_pix;
        end else if (e_done) begin
            r_e_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (xfer) begin
            r_e_mask   <= a_mask;
            r_e_blk    <= a_first;
            r_e_pix    <= '0;
            r_e_col    <= r_a_col;
            r_e_row    <= r_a_row;
            r_e_cur    <= r_a_cur;
            r_e_above  <= above_pix;
            r_e_lcur   <= r_left_cur;
            r_e_labove <= r_left_above;
        end else if (emit) begin
            r_e_pix <= r_e_pix + 2'd1;
            if (r_e_pix == PIX_LAST) begin
                r_e_blk <= nxt_blk;
            end
        end
    end

    // neighbour selection and result value for the current block and pixel
    pupda_pkg::t_pix s0, s1, s2, s3, res_pix;
    logic [CW-1:0]   bx;
    logic [RW-1:0]   by;
    logic [CW:0]     tx;
    logic [RW:0]     ty;

    always_comb begin
        case (r_e_blk)
            BLK_UP_LEFT: begin
                s0 = r_e_labove; s1 = r_e_above; s2 = r_e_lcur; s3 = r_e_cur;
            end
            BLK_UP: begin
                s0 = r_e_above;  s1 = r_e_above; s2 = r_e_cur;  s3 = r_e_cur;
            end
            BLK_LEFT: begin
                s0 = r_e_lcur;   s1 = r_e_cur;   s2 = r_e_lcur; s3 = r_e_cur;
            end
            default: begin
                s0 = r_e_cur;    s1 = r_e_cur;   s2 = r_e_cur;  s3 = r_e_cur;
            end
        endcase
        case (r_e_pix)
            2'd0:    res_pix = s0;
            2'd1:    res_pix = pupda_pkg::pix_avg2(s0, s1);
            2'd2:    res_pix = pupda_pkg::pix_avg2(s0, s2);
            default: res_pix = pupda_pkg::pix_avg4(s0, s1, s2, s3);
        endcase
        // left-hand blocks sit one column back, upper blocks one row up
        bx = r_e_blk[0] ? r_e_col : r_e_col - CW'(1);
        by = r_e_blk[1] ? r_e_row : r_e_row - RW'(1);
        tx = {bx, r_e_pix[0]};
        ty = {by, r_e_pix[1]};
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (emit) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_out_x      <= pupda_pkg::COORD_W'(tx);
            o_out_y      <= pupda_pkg::COORD_W'(ty);
            o_out_blue   <= res_pix[0*pupda_pkg::CHAN_W +: pupda_pkg::CHAN_W];
            o_out_green  <= res_pix[1*pupda_pkg::CHAN_W +: pupda_pkg::CHAN_W];
            o_out_red    <= res_pix[2*pupda_pkg::CHAN_W +: pupda_pkg::CHAN_W];
            o_out_alpha  <= res_pix[3*pupda_pkg::CHAN_W +: pupda_pkg::CHAN_W];
            o_out_last   <= (r_e_pix == PIX_LAST) && !nxt_found;
            o_frame_done <= (r_e_pix == PIX_LAST) && (r_e_blk == BLK_CORNER);
        end
    end

    // ---------------- assertions ----------------
    a_emit_blk_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e_valid |-> r_e_mask[r_e_blk])
        else $error("emitter on a block that is not complete");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_done |-> o_out_last)
        else $error("frame end not on the last result of an item");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && !xfer |=> r_a_valid && $stable(r_a_cur) && $stable(above_pix))
        else $error("staged item or its line RAM data lost while waiting");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_col <= r_w_last)
        else $error("column counter beyond image width");

    a_no_accept_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && r_e_valid && !e_done |-> !o_in_ready)
        else $error("item accepted with staging and emitter both occupied");

endmodule
`default_nettype wire

// File: rtl/pupda_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pupda_ram: simple dual-port RAM, registered read
// One write and one read port; a read of the address written in the same
// cycle returns the old contents.
// ----------------------------------------------------------------------------
module pupda_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire                      i_re,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the 2x upscaler with neighbour averaging
// Source pixels are offered in raster order under a range of frame sizes,
// every target pixel is predicted or typed in and compared as it leaves.
// ----------------------------------------------------------------------------
module tb;
    import pupda_pkg::*;

    // one target pixel as it leaves the block
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [CHAN_W-1:0]  blue;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  alpha;
        logic               last;
        logic               done;
    } t_tgt_px;

    // directed stimulus row: a register write or a source pixel
    typedef enum logic {ROW_CFG, ROW_PIX} t_row_kind;
    typedef struct packed {
        t_row_kind        kind;
        logic             cfg_idx;
        logic [CFG_W-1:0] cfg_val;
        t_pix             pix;
        logic             typed;    // expectation typed in rather than predicted
        logic             has_blk;  // typed: one uniform block at (0,0), frame done
    } t_stim_row;

    // ------------------------------------------------------------------------
    // DUT hook-up; every input starts at a known value
    // ------------------------------------------------------------------------
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic               i_cfg_idx   = 1'b0;
    logic [CFG_W-1:0]   i_cfg_data  = '0;
    logic               i_in_valid  = 1'b0;
    logic [CHAN_W-1:0]  i_in_blue   = '0;
    logic [CHAN_W-1:0]  i_in_green  = '0;
    logic [CHAN_W-1:0]  i_in_red    = '0;
    logic [CHAN_W-1:0]  i_in_alpha  = '0;
    logic               i_out_ready = 1'b0;
    wire                o_in_ready;
    wire                o_out_valid;
    wire  [COORD_W-1:0] o_out_x;
    wire  [COORD_W-1:0] o_out_y;
    wire  [CHAN_W-1:0]  o_out_blue;
    wire  [CHAN_W-1:0]  o_out_green;
    wire  [CHAN_W-1:0]  o_out_red;
    wire  [CHAN_W-1:0]  o_out_alpha;
    wire                o_out_last;
    wire                o_frame_done;

    pixel_upscale_double_averaging_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_blue    (i_in_blue),
        .i_in_green   (i_in_green),
        .i_in_red     (i_in_red),
        .i_in_alpha   (i_in_alpha),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_out_blue   (o_out_blue),
        .o_out_green  (o_out_green),
        .o_out_red    (o_out_red),
        .o_out_alpha  (o_out_alpha),
        .o_out_last   (o_out_last),
        .o_frame_done (o_frame_done)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    t_tgt_px   px_expect [$];   // target pixels still owed by the block, oldest first
    t_tgt_px   fresh_px [$];    // blocks released by the item being predicted
    t_stim_row stim_rows [$];

    // local copy of the upscaler state
    t_pix             line_mem [0:MAX_WIDTH_DEF-1];  // previous source row
    int               col        = 0;
    int               row        = 0;
    t_pix             left_cur   = '0;
    t_pix             left_above = '0;
    logic [CFG_W-1:0] cfg_w      = 1;
    logic [CFG_W-1:0] cfg_h      = 1;

    bit tx_idle = 1'b1;  // sender inserts random gaps
    bit rx_idle = 1'b1;  // receiver inserts random stalls
    bit rx_hold = 1'b0;  // ask the receiver for one long hold-off

    int mismatch_cnt = 0;
    int px_checked   = 0;
    int px_sent      = 0;
    int reg_writes   = 0;

    t_tgt_px want_px;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // register value as the block uses it: zero reads as 1, large saturates
    function automatic int eff_dim(input logic [CFG_W-1:0] v, input int lim);
        if (v == 0) return 1;
        if (v > lim) return lim;
        return int'(v);
    endfunction

    // per channel (a+b+c+d) >> sh, truncating
    function automatic t_pix chan_mean(input t_pix a, input t_pix b, input t_pix c,
                                       input t_pix d, input int sh);
        t_pix res;
        int   sum;
        res = '0;
        for (int k = 0; k < 4; k++) begin
            sum = a[k*CHAN_W +: CHAN_W] + b[k*CHAN_W +: CHAN_W]
                + c[k*CHAN_W +: CHAN_W] + d[k*CHAN_W +: CHAN_W];
            res[k*CHAN_W +: CHAN_W] = CHAN_W'(sum >> sh);
        end
        return res;
    endfunction

    function automatic t_tgt_px mk_px(input int x, input int y, input t_pix p);
        t_tgt_px t;
        t.x     = x[COORD_W-1:0];   // coordinates wrap at 4096
        t.y     = y[COORD_W-1:0];
        t.blue  = p[7:0];
        t.green = p[15:8];
        t.red   = p[23:16];
        t.alpha = p[31:24];
        t.last  = 1'b0;
        t.done  = 1'b0;
        return t;
    endfunction

    // 2x2 target block for source (bx,by): s1 right, s2 below, s3 diagonal
    task automatic add_block(input int bx, input int by, input t_pix s0, input t_pix s1,
                             input t_pix s2, input t_pix s3);
        fresh_px.push_back(mk_px(2*bx,     2*by,     s0));
        fresh_px.push_back(mk_px(2*bx + 1, 2*by,     chan_mean(s0, s1, '0, '0, 1)));
        fresh_px.push_back(mk_px(2*bx,     2*by + 1, chan_mean(s0, s2, '0, '0, 1)));
        fresh_px.push_back(mk_px(2*bx + 1, 2*by + 1, chan_mean(s0, s1, s2, s3, 2)));
    endtask

    // tag the item's final pixel and hand everything over to the checker
    task automatic seal_block_px(input bit fin);
        t_tgt_px t;
        if (fresh_px.size() > 0) begin
            t = fresh_px.pop_back();
            t.last = 1'b1;
            t.done = fin;
            fresh_px.push_back(t);
        end
        foreach (fresh_px[i]) px_expect.push_back(fresh_px[i]);
        fresh_px.delete();
    endtask

    // One accepted source pixel: release every block whose neighbours are now
    // known, then advance the raster position. keep = 0 only updates state.
    task automatic upscale_pixel(input t_pix cur, input bit keep);
        int   w;
        int   h;
        int   c;
        int   r;
        t_pix above;
        bit   fin;
        w   = eff_dim(cfg_w, MAX_WIDTH_DEF);
        h   = eff_dim(cfg_h, MAX_HEIGHT_DEF);
        c   = (col >= w) ? 0 : col;
        r   = (row >= h) ? 0 : row;
        fin = 1'b0;
        above = line_mem[c];
        if (r >= 1) begin
            // blocks of the row above now have their lower neighbours
            if (c >= 1) add_block(c - 1, r - 1, left_above, above, left_cur, cur);
            if (c == w - 1) add_block(c, r - 1, above, above, cur, cur);
        end
        if (r == h - 1) begin
            // bottom row: the row below is the row itself
            if (c >= 1) add_block(c - 1, r, left_cur, cur, left_cur, cur);
            if (c == w - 1) begin
                add_block(c, r, cur, cur, cur, cur);
                fin = 1'b1;
            end
        end
        line_mem[c] = cur;
        left_above  = above;
        left_cur    = cur;
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col = c;
        row = r;
        if (keep) begin
            seal_block_px(fin);
        end else begin
            fresh_px.delete();
        end
    endtask

    // ------------------------------------------------------------------------
    // Drivers (inputs change on the falling edge)
    // ------------------------------------------------------------------------

    // drop valid and wait for every owed pixel, then let items that release
    // nothing clear the pipeline
    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (px_expect.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // register write also restarts the frame
    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        settle();
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(posedge i_clk);
        if (idx == CFG_SRC_WIDTH) begin
            cfg_w = val;
        end else begin
            cfg_h = val;
        end
        col = 0;
        row = 0;
        reg_writes++;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic send_pixel(input t_pix p, input bit keep);
        int gap;
        gap = tx_idle ? $urandom_range(0, 3) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        {i_in_alpha, i_in_red, i_in_green, i_in_blue} = p;
        do @(posedge i_clk); while (!o_in_ready);
        upscale_pixel(p, keep);
        px_sent++;
    endtask

    task automatic add_cfg(input logic idx, input logic [CFG_W-1:0] val);
        t_stim_row s;
        s         = '0;
        s.kind    = ROW_CFG;
        s.cfg_idx = idx;
        s.cfg_val = val;
        stim_rows.push_back(s);
    endtask

    task automatic add_pix(input t_pix p, input bit typed, input bit has_blk);
        t_stim_row s;
        s         = '0;
        s.kind    = ROW_PIX;
        s.pix     = p;
        s.typed   = typed;
        s.has_blk = has_blk;
        stim_rows.push_back(s);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int gap;
        wait (i_rst_n);
        forever begin
            if (rx_hold) begin
                // long enough for the staged and emitting items to fill up
                @(negedge i_clk);
                i_out_ready = 1'b0;
                repeat (300) @(negedge i_clk);
                rx_hold = 1'b0;
            end
            gap = rx_idle ? $urandom_range(0, 3) : 0;
            repeat (gap) begin
                @(negedge i_clk);
                i_out_ready = 1'b0;
            end
            @(negedge i_clk);
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // ------------------------------------------------------------------------
    // Checker: outputs sampled on the rising edge
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (px_expect.size() == 0) begin
                $display("%0t: result expected none, got pixel at (%0d,%0d)",
                         $time, o_out_x, o_out_y);
                mismatch_cnt++;
            end else begin
                want_px = px_expect.pop_front();
                check_field("x",          32'(want_px.x),     32'(o_out_x));
                check_field("y",          32'(want_px.y),     32'(o_out_y));
                check_field("blue",       32'(want_px.blue),  32'(o_out_blue));
                check_field("green",      32'(want_px.green), 32'(o_out_green));
                check_field("red",        32'(want_px.red),   32'(o_out_red));
                check_field("alpha",      32'(want_px.alpha), 32'(o_out_alpha));
                check_field("last",       32'(want_px.last),  32'(o_out_last));
                check_field("frame_done", 32'(want_px.done),  32'(o_frame_done));
                px_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog, well above the slowest correct run
    // ------------------------------------------------------------------------
    initial begin
        #3_000_000;
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int w;
        int h;
        int n;
        int mode;
        int phase;
        int rand_cnt;
        int wait_cnt;
        t_pix p;

        // after reset the frame is 1x1: each pixel is its own uniform block
        add_pix(32'h0000_0000, 1'b1, 1'b1);
        add_pix(32'hFFFF_FFFF, 1'b1, 1'b1);
        add_pix(32'hA55A_C33C, 1'b1, 1'b1);
        // zero in either register reads as 1
        add_cfg(CFG_SRC_WIDTH, 12'd0);
        add_pix(32'h1234_5678, 1'b1, 1'b1);
        add_cfg(CFG_SRC_HEIGHT, 12'd0);
        add_pix(32'h8080_8080, 1'b1, 1'b1);
        // single row: right edge clamps, average of full and empty channels
        add_cfg(CFG_SRC_WIDTH, 12'd2);
        add_cfg(CFG_SRC_HEIGHT, 12'd1);
        add_pix(32'hFFFF_FFFF, 1'b1, 1'b0);
        add_pix(32'h0000_0000, 1'b0, 1'b0);
        // single column: bottom edge clamps
        add_cfg(CFG_SRC_WIDTH, 12'd1);
        add_cfg(CFG_SRC_HEIGHT, 12'd2);
        add_pix(32'h0102_0304, 1'b1, 1'b0);
        add_pix(32'hFEFD_FCFB, 1'b0, 1'b0);
        // width saturates at the maximum
        add_cfg(CFG_SRC_WIDTH, 12'd4095);
        add_cfg(CFG_SRC_HEIGHT, 12'd1);
        add_pix(32'hFFFF_FFFF, 1'b1, 1'b0);
        add_pix(32'hFFFF_FFFF, 1'b0, 1'b0);
        add_pix(32'h0101_0101, 1'b0, 1'b0);
        // height saturates too; first row of a tall frame releases nothing
        add_cfg(CFG_SRC_WIDTH, 12'd1);
        add_cfg(CFG_SRC_HEIGHT, 12'd4095);
        add_pix(32'h0000_0000, 1'b1, 1'b0);
        add_pix(32'hFFFF_FFFF, 1'b0, 1'b0);
        add_pix(32'h7F80_7F80, 1'b0, 1'b0);
        // a complete 3x3 frame: corner, edges and interior
        add_cfg(CFG_SRC_WIDTH, 12'd3);
        add_cfg(CFG_SRC_HEIGHT, 12'd3);
        repeat (9) add_pix(t_pix'($urandom), 1'b0, 1'b0);

        // synchronous reset, once
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed rows; typed rows still advance the predictor's state
        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_CFG) begin
                write_reg(stim_rows[i].cfg_idx, stim_rows[i].cfg_val);
            end else begin
                p = stim_rows[i].pix;
                send_pixel(p, !stim_rows[i].typed);
                if (stim_rows[i].typed) begin
                    if (stim_rows[i].has_blk) add_block(0, 0, p, p, p, p);
                    seal_block_px(stim_rows[i].has_blk);
                end
            end
        end

        // random phases: mostly whole small frames, some cut short by a
        // restart, a few huge sizes run for a handful of pixels only
        phase    = 0;
        rand_cnt = 0;
        while (rand_cnt < 346) begin
            mode = $urandom_range(0, 9);
            if (phase == 0) begin
                w = 6;
                h = 5;
            end else if (mode == 0) begin
                case ($urandom_range(0, 3))
                    0: begin w = 2048; h = 1; end
                    1: begin w = 1; h = 2048; end
                    2: begin w = $urandom_range(2049, 4095); h = 1; end
                    default: begin w = $urandom_range(2049, 4095);
                                   h = $urandom_range(2049, 4095); end
                endcase
            end else if (mode == 1) begin
                w = $urandom_range(7, 40);
                h = $urandom_range(1, 2);
            end else begin
                w = $urandom_range(0, 6);
                h = $urandom_range(0, 6);
            end

            if ($urandom_range(0, 1)) begin
                write_reg(CFG_SRC_WIDTH, CFG_W'(w));
                write_reg(CFG_SRC_HEIGHT, CFG_W'(h));
            end else begin
                write_reg(CFG_SRC_HEIGHT, CFG_W'(h));
                write_reg(CFG_SRC_WIDTH, CFG_W'(w));
            end

            if (mode == 0 && phase != 0) begin
                n = $urandom_range(5, 20);
            end else begin
                n = eff_dim(CFG_W'(w), MAX_WIDTH_DEF) * eff_dim(CFG_W'(h), MAX_HEIGHT_DEF);
                n = n * $urandom_range(1, 2)
                  + (($urandom_range(0, 4) == 0) ? $urandom_range(0, n - 1) : 0);
            end

            // first phase: sender flat out while the receiver holds off, so
            // the block fills and back-pressures its input
            tx_idle = (phase != 0) && ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            if (phase == 0) rx_hold = 1'b1;

            for (int i = 0; i < n && rand_cnt < 346; i++) begin
                if (rand_cnt == 200 || $urandom_range(0, 59) == 0) settle();
                send_pixel(t_pix'($urandom), 1'b1);
                rand_cnt++;
            end
            phase++;
        end

        // drain, with a limit of its own
        @(negedge i_clk);
        i_in_valid = 1'b0;
        wait_cnt = 0;
        while (px_expect.size() != 0 && wait_cnt < 50000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (20) @(posedge i_clk);
        if (px_expect.size() != 0) begin
            $display("%0t: %0d target pixels expected, never delivered",
                     $time, px_expect.size());
            mismatch_cnt++;
        end

        $display("Run covered %0d source pixels under %0d register writes,", px_sent,
                 reg_writes);
        $display("%0d target pixels compared, including stalls and frame restarts.",
                 px_checked);
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/pupda_pkg.sv
rtl/pupda_ram.sv
rtl/pixel_upscale_double_averaging_unit.sv
test/tb.sv
